### sv/ise_pkg.sv
// Shared widths and codes for the interpolation search engine.
// No dependencies; every other file refers to it by scoped names.
package ise_pkg;

   localparam int KEY_W     = 32;
   localparam int POS_W     = 5;
   localparam int CSR_W     = 6;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_W-1:0] ENTRIES_RESET = 6'd32;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

endpackage

### sv/ise_table.sv
// Value table of the interpolation search engine: one write port, one
// registered read port. Depends on ise_pkg for the value width.
module ise_table #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [ise_pkg::KEY_W-1:0]  wr_data,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [ise_pkg::KEY_W-1:0]  rd_data_ff
);

   logic signed [ise_pkg::KEY_W-1:0] mem [DEPTH];

   // store one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

### sv/ise_divider.sv
// Probe offset unit: one registered multiply, then a restoring divide that
// yields one quotient bit per cycle. Depends on ise_pkg for the value width.
module ise_divider #(
   parameter int IDX_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [IDX_W-1:0]              span,
   input  logic [ise_pkg::KEY_W-1:0]     diff,
   input  logic [ise_pkg::KEY_W-1:0]     den,
   output logic                          done_ff,
   output logic [IDX_W-1:0]              quot_ff
);

   localparam int PW = IDX_W + ise_pkg::KEY_W;
   localparam int CW = $clog2(IDX_W + 1);

   logic                       busy_ff;
   logic                       mul_ff;
   logic [IDX_W-1:0]           span_ff;
   logic [ise_pkg::KEY_W-1:0]  diff_ff;
   logic [PW-1:0]              rem_ff;
   logic [PW-1:0]              den_sh_ff;
   logic [CW-1:0]              cnt_ff;
   logic [PW-1:0]              prod;
   logic                       ge;

   assign prod = span_ff * diff_ff;
   assign ge   = (rem_ff >= den_sh_ff);

   // control: capture, multiply, then one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            mul_ff  <= 1'b1;
         end else if (busy_ff && mul_ff) begin
            mul_ff <= 1'b0;
         end else if (busy_ff && (cnt_ff == CW'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         span_ff   <= span;
         diff_ff   <= diff;
         den_sh_ff <= PW'(den) << (IDX_W - 1);
         quot_ff   <= '0;
         cnt_ff    <= CW'(IDX_W);
      end else if (busy_ff && mul_ff) begin
         rem_ff <= prod;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - den_sh_ff;
         end
         quot_ff   <= (quot_ff << 1) | IDX_W'(ge);
         den_sh_ff <= den_sh_ff >> 1;
         cnt_ff    <= cnt_ff - CW'(1);
      end
   end

endmodule

### sv/interpolation_search_engine_unit.sv
// Interpolation search engine over a table of signed 32-bit values.
// A write transfer gives no result. A search answers on rsp_tvalid; each probe
// costs three table reads and, unless the range is flat, one bit-per-cycle divide.
// One item is in work at a time; the next can be taken in the same cycle that the
// result is offered. Synchronous reset clears control state and sets entries_in_use
// to 32; table contents are undefined.
module interpolation_search_engine_unit #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // kind
   input  logic [ise_pkg::REQ_DATA_W-1:0]      req_tdata,   // entry_index[4:0], value[36:5]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,   // found
   output logic [ise_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // found_index[4:0]
   input  logic                                csr_we,
   input  logic [ise_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SW    = IDX_W + 2;
   localparam int KW    = ise_pkg::KEY_W;
   localparam int PW    = ise_pkg::POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD_LO  = 3'd1;
   localparam logic [2:0] S_RD_HI  = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_RD_P   = 3'd5;
   localparam logic [2:0] S_CMP    = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [ise_pkg::CSR_W-1:0] entries_ff;
   logic signed [SW-1:0]      lo_ff, lo_in;
   logic signed [SW-1:0]      hi_ff, hi_in;
   logic [IDX_W-1:0]          probe_ff, probe_in;
   logic signed [KW-1:0]      key_ff, key_in;
   logic signed [KW-1:0]      vlo_ff, vlo_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [PW-1:0]             rsp_index_ff;

   logic                      req_xfer;
   logic [PW-1:0]             req_pos;
   logic signed [KW-1:0]      req_value;
   logic                      tbl_we;
   logic [IDX_W-1:0]          rd_addr;
   logic signed [KW-1:0]      rd_data;
   logic signed [SW-1:0]      n_use;
   logic signed [SW-1:0]      probe_ext;
   logic signed [SW-1:0]      next_lo;
   logic signed [SW-1:0]      next_hi;
   logic                      div_start;
   logic                      div_done;
   logic [IDX_W-1:0]          div_quot;
   logic [KW-1:0]             key_diff;
   logic [KW-1:0]             val_span;
   logic                      out_free;

   assign req_pos    = req_tdata[PW-1:0];
   assign req_value  = req_tdata[PW+KW-1:PW];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign tbl_we     = req_xfer && (req_tuser == ise_pkg::KIND_WRITE)
                       && (32'(req_pos) < TABLE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = ise_pkg::RSP_DATA_W'(rsp_index_ff);

   // clamp the entry count to the table depth
   always_comb begin
      if (32'(entries_ff) > TABLE_DEPTH) begin
         n_use = SW'(TABLE_DEPTH);
      end else begin
         n_use = SW'(entries_ff);
      end
   end

   // unsigned distances; both are non-negative once the range check passed
   assign key_diff  = key_ff - vlo_ff;
   assign val_span  = rd_data - vlo_ff;
   assign probe_ext = SW'(probe_ff);
   assign next_lo   = probe_ext + SW'(1);
   assign next_hi   = probe_ext - SW'(1);

   // pick the table read address for each step
   always_comb begin
      unique case (state_ff)
         S_RD_LO: rd_addr = lo_ff[IDX_W-1:0];
         S_RD_HI: rd_addr = hi_ff[IDX_W-1:0];
         default: rd_addr = probe_ff;
      endcase
   end

   ise_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (IDX_W'(req_pos)),
      .wr_data    (req_value),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   ise_divider #(
      .IDX_W (IDX_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .span    (IDX_W'(hi_ff - lo_ff)),
      .diff    (key_diff),
      .den     (val_span),
      .done_ff (div_done),
      .quot_ff (div_quot)
   );

   // search sequencer
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      probe_in  = probe_ff;
      key_in    = key_ff;
      vlo_in    = vlo_ff;
      hit_in    = hit_ff;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_tuser == ise_pkg::KIND_SEARCH)) begin
               key_in = req_value;
               lo_in  = '0;
               hi_in  = n_use - SW'(1);
               hit_in = 1'b0;
               if (n_use == '0) begin
                  state_in = S_RESULT;
               end else begin
                  state_in = S_RD_LO;
               end
            end
         end
         S_RD_LO: state_in = S_RD_HI;
         S_RD_HI: begin
            vlo_in   = rd_data;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // key outside the end values: not found
            if ((key_ff < vlo_ff) || (key_ff > rd_data)) begin
               state_in = S_RESULT;
            end else if (rd_data == vlo_ff) begin
               probe_in = lo_ff[IDX_W-1:0];
               state_in = S_RD_P;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               probe_in = IDX_W'(lo_ff + SW'(div_quot));
               state_in = S_RD_P;
            end
         end
         S_RD_P: state_in = S_CMP;
         S_CMP: begin
            // narrow the range around the probe
            if (rd_data == key_ff) begin
               hit_in   = 1'b1;
               state_in = S_RESULT;
            end else if (rd_data < key_ff) begin
               lo_in    = next_lo;
               state_in = (next_lo <= hi_ff) ? S_RD_LO : S_RESULT;
            end else begin
               hi_in    = next_hi;
               state_in = (lo_ff <= next_hi) ? S_RD_LO : S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= ise_pkg::ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            entries_ff <= csr_wdata;
         end
         if ((state_ff == S_RESULT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      probe_ff <= probe_in;
      key_ff   <= key_in;
      vlo_ff   <= vlo_in;
      hit_ff   <= hit_in;
      if ((state_ff == S_RESULT) && out_free) begin
         rsp_found_ff <= hit_ff;
         rsp_index_ff <= hit_ff ? PW'(probe_ff) : '0;
      end
   end

endmodule

### tb/interpolation_search_engine_unit_test.sv
// Self-checking bench for interpolation_search_engine_unit: streams table writes and key
// searches, predicts each search answer and checks every rsp transfer against it.
// Depends on ise_pkg and the engine RTL only.
module interpolation_search_engine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 32;
   localparam int IDLE_LIMIT    = 4000;  // covers the worst search plus the longest receiver stall
   localparam int CSR_SETTLE    = 16;    // idle margin before a csr write
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_ITEMS  = 1820;
   localparam logic signed [ise_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [ise_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic                              kind;
      logic [ise_pkg::POS_W-1:0]         entry_index;
      logic signed [ise_pkg::KEY_W-1:0]  value;
   } table_op_type;

   typedef struct {
      logic                      found;
      logic [ise_pkg::POS_W-1:0] found_index;
   } search_answer_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic                           req_tuser  = 1'b0;   // kind
   logic [ise_pkg::REQ_DATA_W-1:0] req_tdata  = '0;     // entry_index[4:0], value[36:5]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           rsp_tuser;           // found
   logic [ise_pkg::RSP_DATA_W-1:0] rsp_tdata;           // found_index[4:0]
   logic                           csr_we     = 1'b0;
   logic [ise_pkg::CSR_W-1:0]      csr_wdata  = '0;

   // table as the engine should hold it, updated per accepted write; entry count as set_entries sets it
   logic signed [ise_pkg::KEY_W-1:0] table_copy [DEPTH];
   logic [ise_pkg::CSR_W-1:0]        entries_copy = ise_pkg::ENTRIES_RESET;
   // table contents as the stimulus will leave them, used to pick keys
   logic signed [ise_pkg::KEY_W-1:0] staged [DEPTH];

   table_op_type      pending_ops [$];
   search_answer_type awaited_answers [$];
   int  ops_queued   = 0;
   int  ops_taken    = 0;
   int  mismatches   = 0;
   bit  req_taken    = 1'b0;
   int  burst_left   = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   int  calm_left    = 0;
   int  quiet_cycles = 0;

   interpolation_search_engine_unit #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Interpolation search over the first entries_in_use entries of the table copy.
   function automatic search_answer_type predict_search(
      input logic signed [ise_pkg::KEY_W-1:0] key);
      search_answer_type ans;
      longint lo, hi, probe, v_lo, v_hi, v_probe;
      ans.found       = 1'b0;
      ans.found_index = '0;
      lo = 0;
      hi = longint'(entries_copy);
      if (hi > DEPTH) hi = DEPTH;
      hi = hi - 1;
      while (lo <= hi) begin
         v_lo = table_copy[lo];
         v_hi = table_copy[hi];
         // key outside the end values: stop as not found
         if (key < v_lo || key > v_hi) return ans;
         // flat range: probe at the low end; else multiply before divide
         if (v_hi == v_lo) probe = lo;
         else probe = lo + ((hi - lo) * (longint'(key) - v_lo)) / (v_hi - v_lo);
         v_probe = table_copy[probe];
         if (v_probe == key) begin
            ans.found       = 1'b1;
            ans.found_index = probe[ise_pkg::POS_W-1:0];
            return ans;
         end
         if (v_probe < key) lo = probe + 1;
         else hi = probe - 1;
      end
      return ans;
   endfunction

   task automatic queue_op(input logic kind, input logic [ise_pkg::POS_W-1:0] idx,
                           input logic signed [ise_pkg::KEY_W-1:0] value);
      table_op_type op;
      op.kind        = kind;
      op.entry_index = idx;
      op.value       = value;
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   // Wait until every queued item is taken and every search has answered.
   task automatic drain();
      do @(negedge clock);
      while (ops_taken != ops_queued || awaited_answers.size() != 0);
   endtask

   // Write entries_in_use while the engine is idle.
   task automatic set_entries(input logic [ise_pkg::CSR_W-1:0] count);
      drain();
      repeat (CSR_SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(negedge clock);
      csr_we       <= 1'b0;
      entries_copy  = count;
   endtask

   // Offer request transfers in bursts with random gaps; hold an item until taken.
   always @(negedge clock) begin
      table_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the current item
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (pending_ops.size() > 0) begin
         op = pending_ops.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= op.kind;
         req_tdata  <= {{(ise_pkg::REQ_DATA_W-ise_pkg::KEY_W-ise_pkg::POS_W){1'b0}},
                        op.value, op.entry_index};
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver readiness: mostly ready, short and long stalls, calm stretches.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         case ($urandom_range(0, 15))
            0:          calm_left  = $urandom_range(20, 200);
            1:          stall_left = $urandom_range(10, 40);
            2, 3, 4, 5: stall_left = $urandom_range(1, 4);
            default:    ;
         endcase
      end
   end

   // Apply each accepted request: update the table copy or predict the answer.
   always @(posedge clock) begin
      logic signed [ise_pkg::KEY_W-1:0] key;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            ops_taken++;
            key = req_tdata[ise_pkg::POS_W +: ise_pkg::KEY_W];
            if (req_tuser == ise_pkg::KIND_WRITE) table_copy[req_tdata[ise_pkg::POS_W-1:0]] = key;
            else awaited_answers.push_back(predict_search(key));
         end
      end
   end

   // Check each response transfer against the oldest predicted answer.
   always @(posedge clock) begin
      search_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected response found=%0b index=%0d",
                     $time, rsp_tuser, rsp_tdata[ise_pkg::POS_W-1:0]);
            mismatches++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[ise_pkg::POS_W-1:0] !== want.found_index) begin
               $display("%0t: found_index expected %0d actual %0d",
                        $time, want.found_index, rsp_tdata[ise_pkg::POS_W-1:0]);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run after too long without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[interpolation_search_engine_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i, j, fill, span, n_search, pick, style;
      longint cur, step, lin_step;
      logic [ise_pkg::CSR_W-1:0] cfg;
      bit first_load, down, noisy;
      logic signed [ise_pkg::KEY_W-1:0] key;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: extreme values in a four-entry table
      queue_op(ise_pkg::KIND_WRITE, 5'd0, KEY_MIN);
      queue_op(ise_pkg::KIND_WRITE, 5'd1, -32'sd5);
      queue_op(ise_pkg::KIND_WRITE, 5'd2, 32'sd7);
      queue_op(ise_pkg::KIND_WRITE, 5'd3, KEY_MAX);
      set_entries(6'd4);
      queue_op(ise_pkg::KIND_SEARCH, 5'd31, KEY_MIN);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, KEY_MAX);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd7);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd0);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, -32'sd5);
      // empty table, then a single entry with keys inside and above it
      set_entries(6'd0);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd7);
      set_entries(6'd1);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, KEY_MIN);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, -32'sd5);
      // equal end values
      for (i = 0; i < 4; i++) queue_op(ise_pkg::KIND_WRITE, ise_pkg::POS_W'(i), 32'sd9);
      set_entries(6'd4);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd9);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd8);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd10);
      // unsorted table
      queue_op(ise_pkg::KIND_WRITE, 5'd0, 32'sd50);
      queue_op(ise_pkg::KIND_WRITE, 5'd1, 32'sd10);
      queue_op(ise_pkg::KIND_WRITE, 5'd2, 32'sd30);
      queue_op(ise_pkg::KIND_WRITE, 5'd3, 32'sd20);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd30);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd20);
      queue_op(ise_pkg::KIND_SEARCH, 5'd0, 32'sd10);

      // random phases: load a sorted table, then search it
      first_load = 1'b1;
      while (ops_queued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       cfg = 6'd0;
            1:       cfg = 6'd1;
            2:       cfg = 6'd32;
            3:       cfg = 6'd63;
            4:       cfg = ise_pkg::CSR_W'($urandom_range(33, 62));
            5:       cfg = 6'd2;
            default: cfg = ise_pkg::CSR_W'($urandom_range(1, 32));
         endcase
         span = (int'(cfg) > DEPTH) ? DEPTH : int'(cfg);
         set_entries(cfg);

         // the first load covers the whole table so no search reads an unwritten entry
         fill = first_load ? DEPTH : ((span == 0) ? 4 : span);
         first_load = 1'b0;
         style      = $urandom_range(0, 4);
         lin_step   = $urandom_range(1, 100000);
         step       = 64'sd4294967295 / fill;
         if (style == 0) cur = longint'(KEY_MIN) + longint'($urandom_range(0, 3));
         else cur = longint'($signed($urandom()));
         for (i = 0; i < fill; i++) begin
            if (cur > longint'(KEY_MAX)) cur = longint'(KEY_MAX);
            staged[i] = cur[ise_pkg::KEY_W-1:0];
            case (style)
               0:       cur += longint'($urandom()) % (step + 1);  // spread over the range
               1:       cur += $urandom_range(0, 2);               // dense, duplicates
               2:       cur += lin_step;                           // evenly spaced
               3:       cur += longint'(1) << $urandom_range(0, i); // skewed growth
               default: ;                                          // all equal
            endcase
         end
         down = $urandom_range(0, 1);
         for (i = 0; i < fill; i++) begin
            j = down ? fill - 1 - i : i;
            queue_op(ise_pkg::KIND_WRITE, ise_pkg::POS_W'(j), staged[j]);
         end

         // searches: mostly present keys, some gaps, random and extreme keys
         noisy    = ($urandom_range(0, 5) == 0);
         n_search = $urandom_range(15, 40);
         for (i = 0; i < n_search; i++) begin
            if (noisy && $urandom_range(0, 7) == 0) begin
               // break the order with a stray write
               j = $urandom_range(0, DEPTH - 1);
               staged[j] = $urandom();
               queue_op(ise_pkg::KIND_WRITE, ise_pkg::POS_W'(j), staged[j]);
            end
            pick = $urandom_range(0, 19);
            j    = (span > 0) ? $urandom_range(0, span - 1) : 0;
            if (pick < 13) key = staged[j];
            else if (pick < 16) key = staged[j] + 1;
            else if (pick < 18) key = $urandom();
            else if (pick == 18) key = KEY_MIN;
            else key = KEY_MAX;
            queue_op(ise_pkg::KIND_SEARCH, ise_pkg::POS_W'($urandom_range(0, 31)), key);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("[interpolation_search_engine_unit] OK");
      end else begin
         $display("[interpolation_search_engine_unit] ERROR");
      end
      $finish;
   end

endmodule
